>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent holds
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lcs_pkg.sv
package lcs_pkg;

  localparam int MOD_WIDTH_DEF = 16;
  localparam int COEFF_W       = 32;
  localparam int CFG_W         = 16;
  localparam int OUT_W         = 16;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_a;
    logic signed [COEFF_W-1:0] coeff_b;
  } in_item_t;

  typedef struct packed {
    logic             solvable;
    logic [OUT_W-1:0] first_solution;
    logic [OUT_W-1:0] spacing;
    logic [OUT_W-1:0] solution_count;
  } out_item_t;

  // divider operations in the order the controller runs them
  typedef enum logic [2:0] {
    OP_RES_A,
    OP_RES_B,
    OP_EUCLID,
    OP_DIV_B,
    OP_DIV_M,
    OP_RES_T,
    OP_RES_X
  } op_t;

  typedef struct packed {
    logic load;
    logic div_go;
    logic capture;
    logic mul;
    logic upd;
    logic mul2;
    logic finish;
    logic ok;
    op_t  op;
  } lcs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic m_zero;
    logic r1_zero;
    logic rem_zero;
  } lcs_status_t;

endpackage

>>> rtl/lcs_div.sv
module lcs_div #(
  parameter int MOD_WIDTH = 16,
  parameter int DIV_W     = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 short_op,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [MOD_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] quot,
  output logic [MOD_WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [MOD_WIDTH:0]   r;
  logic [DIV_W-1:0]     q;
  logic [MOD_WIDTH-1:0] d;
  logic [MOD_WIDTH:0]   trial;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign trial = {r[MOD_WIDTH-1:0], q[DIV_W-1]};
  assign ge    = (trial >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= short_op ? CNT_W'(MOD_WIDTH) : CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      d <= divisor;
      // short operands sit at the top so only MOD_WIDTH steps are needed
      q <= short_op ? (dividend << (DIV_W - MOD_WIDTH)) : dividend;
    end else if (busy) begin
      r <= ge ? (trial - {1'b0, d}) : trial;
      q <= {q[DIV_W-2:0], ge};
    end
  end

  assign quot = q[MOD_WIDTH-1:0];
  assign rem  = r[MOD_WIDTH-1:0];

endmodule

>>> rtl/lcs_dp.sv
module lcs_dp #(
  parameter int MOD_WIDTH = lcs_pkg::MOD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lcs_pkg::CFG_W-1:0]     cfg_data,
  input  lcs_pkg::in_item_t             in_data,
  input  lcs_pkg::lcs_cmd_t             cmd,
  output lcs_pkg::lcs_status_t          status,
  output lcs_pkg::out_item_t            out_data
);

  import lcs_pkg::*;

  localparam int MW    = MOD_WIDTH;
  localparam int TW    = MOD_WIDTH + 2;
  localparam int DIV_W = (2 * MOD_WIDTH > COEFF_W) ? 2 * MOD_WIDTH : COEFF_W;

  logic [MW-1:0]         m;
  logic [COEFF_W-1:0]    a_in;
  logic [COEFF_W-1:0]    b_in;
  logic [COEFF_W-1:0]    abs_a;
  logic [COEFF_W-1:0]    abs_b;
  logic [MW-1:0]         ra;
  logic [MW-1:0]         rb;
  logic [MW-1:0]         r0;
  logic [MW-1:0]         r1;
  logic [MW-1:0]         q;
  logic signed [TW-1:0]  t0;
  logic signed [TW-1:0]  t1;
  logic signed [TW-1:0]  tq;
  logic [TW-1:0]         t_mag;
  logic [MW-1:0]         bp;
  logic [MW-1:0]         mp;
  logic [MW-1:0]         tr;
  logic [MW-1:0]         x0;
  logic [2*MW-1:0]       prod;
  logic [DIV_W-1:0]      div_dividend;
  logic [MW-1:0]         div_divisor;
  logic                  div_short;
  logic                  div_done;
  logic [MW-1:0]         div_quot;
  logic [MW-1:0]         div_rem;

  // turn a remainder of a magnitude into the non-negative residue
  function automatic logic [MW-1:0] fold(input logic [MW-1:0] r, input logic neg,
                                         input logic [MW-1:0] base);
    fold = (neg && r != '0) ? base - r : r;
  endfunction

  assign abs_a = a_in[COEFF_W-1] ? (~a_in + 1'b1) : a_in;
  assign abs_b = b_in[COEFF_W-1] ? (~b_in + 1'b1) : b_in;
  assign t_mag = t0[TW-1] ? (~t0 + 1'b1) : t0;

  always_comb begin
    div_dividend = '0;
    div_divisor  = m;
    div_short    = 1'b1;
    case (cmd.op)
      OP_RES_A: begin
        div_dividend = DIV_W'(abs_a);
        div_short    = 1'b0;
      end
      OP_RES_B: begin
        div_dividend = DIV_W'(abs_b);
        div_short    = 1'b0;
      end
      OP_EUCLID: begin
        div_dividend = DIV_W'(r0);
        div_divisor  = r1;
      end
      OP_DIV_B: begin
        div_dividend = DIV_W'(rb);
        div_divisor  = r0;
      end
      OP_DIV_M: begin
        div_dividend = DIV_W'(m);
        div_divisor  = r0;
      end
      OP_RES_T: begin
        div_dividend = DIV_W'(t_mag[MW-1:0]);
        div_divisor  = mp;
      end
      OP_RES_X: begin
        div_dividend = DIV_W'(prod);
        div_divisor  = mp;
        div_short    = 1'b0;
      end
      default: begin
        div_dividend = '0;
      end
    endcase
  end

  lcs_div #(
    .MOD_WIDTH (MW),
    .DIV_W     (DIV_W)
  ) u_lcs_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .short_op (div_short),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= MW'(2);
    end else if (cfg_we) begin
      m <= MW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_in <= in_data.coeff_a;
      b_in <= in_data.coeff_b;
    end
    if (cmd.capture) begin
      case (cmd.op)
        OP_RES_A: ra <= fold(div_rem, a_in[COEFF_W-1], m);
        OP_RES_B: begin
          rb <= fold(div_rem, b_in[COEFF_W-1], m);
          r0 <= m;
          r1 <= ra;
          t0 <= '0;
          t1 <= TW'(1);
        end
        OP_EUCLID: begin
          q  <= div_quot;
          r0 <= r1;
          r1 <= div_rem;
        end
        OP_DIV_B: bp <= div_quot;
        OP_DIV_M: mp <= div_quot;
        OP_RES_T: tr <= fold(div_rem, t0[TW-1], mp);
        OP_RES_X: x0 <= div_rem;
        default: begin
        end
      endcase
    end
    // the bezout coefficient stays within the modulus, so low bits are exact
    if (cmd.mul) begin
      tq <= $signed({2'b00, q}) * t1;
    end
    if (cmd.upd) begin
      t0 <= t1;
      t1 <= t0 - tq;
    end
    if (cmd.mul2) begin
      prod <= (2*MW)'(tr) * (2*MW)'(bp);
    end
    if (cmd.finish) begin
      out_data.solvable       <= cmd.ok;
      out_data.first_solution <= cmd.ok ? OUT_W'(x0) : '0;
      out_data.spacing        <= cmd.ok ? OUT_W'(mp) : '0;
      out_data.solution_count <= cmd.ok ? OUT_W'(r0) : '0;
    end
  end

  assign status.div_done = div_done;
  assign status.m_zero   = (m == '0);
  assign status.r1_zero  = (r1 == '0);
  assign status.rem_zero = (div_rem == '0);

endmodule

>>> rtl/lcs_ctrl.sv
module lcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lcs_pkg::lcs_status_t status,
  output lcs_pkg::lcs_cmd_t    cmd
);

  import lcs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GO   = 7'b0000010,
    S_WAIT = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  op_t    op;
  op_t    op_next;
  logic   ok;
  logic   ok_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    ok_next    = ok;
    cmd        = '0;
    cmd.op     = op;
    cmd.ok     = ok;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.m_zero) begin
            ok_next    = 1'b0;
            state_next = S_FIN;
          end else begin
            op_next    = OP_RES_A;
            state_next = S_GO;
          end
        end
      end
      S_GO: begin
        // euclid ends once the second remainder reaches zero
        if (op == OP_EUCLID && status.r1_zero) begin
          op_next = OP_DIV_B;
        end else begin
          cmd.div_go = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.div_done) begin
          cmd.capture = 1'b1;
          case (op)
            OP_RES_A: begin
              op_next    = OP_RES_B;
              state_next = S_GO;
            end
            OP_RES_B: begin
              op_next    = OP_EUCLID;
              state_next = S_GO;
            end
            OP_EUCLID: state_next = S_MUL;
            OP_DIV_B: begin
              if (status.rem_zero) begin
                op_next    = OP_DIV_M;
                state_next = S_GO;
              end else begin
                ok_next    = 1'b0;
                state_next = S_FIN;
              end
            end
            OP_DIV_M: begin
              op_next    = OP_RES_T;
              state_next = S_GO;
            end
            OP_RES_T: state_next = S_MUL2;
            OP_RES_X: begin
              ok_next    = 1'b1;
              state_next = S_FIN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_GO;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        op_next    = OP_RES_X;
        state_next = S_GO;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.finish | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_RES_A;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      ok        <= ok_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/linear_congruence_solver.sv
// Solves A*x = B (mod M) for each incoming signed pair (A, B), with M taken from the
// configuration register (reset value 2, write only while the block is idle). A result
// gives whether a solution exists and, if so, the smallest solution x0, the spacing M/g
// and the count g = gcd(A, M) of all solutions below M. Items are handled one at a time
// on a single shared divider that produces one quotient bit per cycle; every division in
// the work is a pass through it, while the products and the Bezout update use their own
// steps. The divider takes dividends of DIV_W = max(32, 2*MOD_WIDTH) bits. A zero
// modulus or a pair with no solution ends early. A finished result waits in the output
// register while the next item is accepted.
module linear_congruence_solver #(
  parameter int MOD_WIDTH = lcs_pkg::MOD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lcs_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lcs_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lcs_pkg::CFG_W-1:0] cfg_data
);

  import lcs_pkg::*;

  lcs_cmd_t    cmd;
  lcs_status_t status;

  assign cfg_ready = 1'b1;

  lcs_ctrl u_lcs_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcs_dp #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_lcs_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> rtl/lcs_checker.sv
`include "assert_macros.svh"

module lcs_checker #(
  parameter int MOD_WIDTH = lcs_pkg::MOD_WIDTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lcs_pkg::out_item_t out_data
);

  import lcs_pkg::*;

  logic stall;
  logic fields_zero;
  logic in_range;

  assign stall       = out_valid && !out_ready;
  assign fields_zero = (out_data.first_solution == '0) && (out_data.spacing == '0) &&
                       (out_data.solution_count == '0);
  assign in_range    = (MOD_WIDTH > OUT_W) ||
                       ((out_data.first_solution < out_data.spacing) &&
                        (out_data.solution_count != '0));

  // a result waiting for the sink keeps its fields
  `ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(out_data), "result changed in stall")

  // no solution means every field reads zero
  `ASSERT_ALWAYS(a_unsolv_zero, !out_valid || out_data.solvable || fields_zero, "bad unsolvable")

  // smallest solution lies below the spacing and the count is nonzero, checked only when the modulus fits in OUT_W bits
  `ASSERT_ALWAYS(a_solv_range, !(out_valid && out_data.solvable) || in_range, "result out of range")

  // an accepted input leaves the solver not ready in the following cycle
  `ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken twice in a row")

  // a new result only appears as the solver finishes, never while it waits for input
  `ASSERT_ALWAYS(a_result_source, !$rose(out_valid) || !$past(in_ready), "result from nowhere")

endmodule

bind linear_congruence_solver lcs_checker #(.MOD_WIDTH(MOD_WIDTH)) u_lcs_checker (.*);
